FILE: hdl/rffp_pkg.sv
// ----------------------------------------------------------------------------
// rffp_pkg
// Shared types and constants of the range/flow frame parser.
// ----------------------------------------------------------------------------
package rffp_pkg;

    localparam int PAYLOAD_BYTES_DEF = 12;
    localparam int FIELD_BYTES       = 9;
    localparam int FIELD_IDX_W       = 4;
    localparam int QUEUE_DEPTH       = 2;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 16;

    localparam logic [7:0]  STRENGTH_MIN = 8'd100;
    // ceil(2^32 / 100), exact floor division by 100 for values below 2^26
    localparam logic [25:0] RECIP_100    = 26'd42949673;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_QUALITY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_X     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_Y     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN         = 3'd7;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] min_range;
        logic [15:0] max_range;
        logic [7:0]  min_flow_quality;
        logic        invert_x;
        logic        invert_y;
        logic [9:0]  flow_gain_percent;
    } t_cfg;

    typedef struct packed {
        logic [15:0] distance;
        logic [15:0] strength;
        logic [15:0] flow_x;
        logic [15:0] flow_y;
        logic [7:0]  quality;
    } t_frame;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

FILE: hdl/range_flow_frame_parser_core.sv
// ----------------------------------------------------------------------------
// range_flow_frame_parser_core
// Range/optical-flow sensor frame parser with checksum and flow scaling.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall / i_rx_byte): one received byte per
// transaction, one byte per cycle unless stalled. o_stall rises only when the
// two-entry frame queue is full, which takes the result receiver holding
// off while two more frames arrive behind a pending result.
// Output channel (o_valid / i_stall / result fields): one transaction per
// frame whose checksum matches. Once the checksum byte is taken, the result
// passes through the queue, the multiply by gain, the multiply by the
// reciprocal of 100 and the output register. While o_valid and i_stall
// are both high the result holds and the pipeline freezes; the parser
// keeps taking bytes into the queue.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index
// and data; write only while the block is idle.
// Reset (synchronous, i_rst_n low): parser waits for the first sync byte,
// queue and pipeline empty, registers back to defaults.
// ----------------------------------------------------------------------------
module range_flow_frame_parser_core #(
    parameter int PAYLOAD_BYTES = rffp_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [7:0]                        i_rx_byte,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [15:0]                       o_distance_cm,
    output logic [15:0]                       o_signal_strength,
    output logic signed [15:0]                o_flow_x_scaled,
    output logic signed [15:0]                o_flow_y_scaled,
    output logic [7:0]                        o_flow_quality,
    output logic                              o_range_ok,
    output logic                              o_flow_ok,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rffp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rffp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rffp_pkg::*;

    t_cfg          r_cfg;
    t_frame        w_push_frame, w_head_frame;
    t_queue_status w_queue;
    logic          w_push, w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first        <= 8'd90;
            r_cfg.sync_second       <= 8'd0;
            r_cfg.min_range         <= 16'd0;
            r_cfg.max_range         <= 16'hFFFF;
            r_cfg.min_flow_quality  <= 8'd0;
            r_cfg.invert_x          <= 1'b0;
            r_cfg.invert_y          <= 1'b0;
            r_cfg.flow_gain_percent <= 10'd100;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SYNC_FIRST:  r_cfg.sync_first        <= i_cfg_data[7:0];
                CFG_SYNC_SECOND: r_cfg.sync_second       <= i_cfg_data[7:0];
                CFG_MIN_RANGE:   r_cfg.min_range         <= i_cfg_data;
                CFG_MAX_RANGE:   r_cfg.max_range         <= i_cfg_data;
                CFG_MIN_QUALITY: r_cfg.min_flow_quality  <= i_cfg_data[7:0];
                CFG_INVERT_X:    r_cfg.invert_x          <= i_cfg_data[0];
                CFG_INVERT_Y:    r_cfg.invert_y          <= i_cfg_data[0];
                CFG_GAIN:        r_cfg.flow_gain_percent <= i_cfg_data[9:0];
                default: begin
                end
            endcase
        end
    end

    rffp_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .i_sync_first  (r_cfg.sync_first),
        .i_sync_second (r_cfg.sync_second),
        .i_queue       (w_queue),
        .o_push        (w_push),
        .o_frame       (w_push_frame)
    );

    rffp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_frame  (w_push_frame),
        .i_pop    (w_pop),
        .o_frame  (w_head_frame),
        .o_status (w_queue)
    );

    rffp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_queue           (w_queue),
        .i_frame           (w_head_frame),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_distance_cm     (o_distance_cm),
        .o_signal_strength (o_signal_strength),
        .o_flow_x_scaled   (o_flow_x_scaled),
        .o_flow_y_scaled   (o_flow_y_scaled),
        .o_flow_quality    (o_flow_quality),
        .o_range_ok        (o_range_ok),
        .o_flow_ok         (o_flow_ok)
    );

endmodule

FILE: hdl/rffp_front.sv
// ----------------------------------------------------------------------------
// rffp_front
// Byte-level frame sync, payload capture and running checksum.
// ----------------------------------------------------------------------------
module rffp_front #(
    parameter int PAYLOAD_BYTES = rffp_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_rx_byte,
    input  logic [7:0]            i_sync_first,
    input  logic [7:0]            i_sync_second,
    input  rffp_pkg::t_queue_status i_queue,
    output logic                  o_push,
    output rffp_pkg::t_frame      o_frame
);
    import rffp_pkg::*;

    localparam int CNT_W = $clog2(PAYLOAD_BYTES);

    typedef enum logic [3:0] {
        S_SYNC1   = 4'b0001,
        S_SYNC2   = 4'b0010,
        S_PAYLOAD = 4'b0100,
        S_CHECK   = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [7:0]         r_sum, n_sum;
    logic [7:0]         r_store [FIELD_BYTES];
    logic               w_accept;
    logic               w_store_en;

    assign o_stall  = i_queue.full;
    assign w_accept = i_valid && !i_queue.full;
    assign w_store_en = w_accept && (r_state == S_PAYLOAD) &&
                        (r_count < CNT_W'(FIELD_BYTES));

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_sum   = r_sum;
        o_push  = 1'b0;
        if (w_accept) begin
            case (r_state)
                S_SYNC1: begin
                    if (i_rx_byte == i_sync_first) begin
                        n_sum   = i_rx_byte;
                        n_state = S_SYNC2;
                    end
                end
                S_SYNC2: begin
                    if (i_rx_byte == i_sync_second) begin
                        n_sum   = r_sum + i_rx_byte;
                        n_count = '0;
                        n_state = S_PAYLOAD;
                    end else begin
                        n_state = S_SYNC1;
                    end
                end
                S_PAYLOAD: begin
                    n_sum   = r_sum + i_rx_byte;
                    n_count = r_count + 1'b1;
                    if (r_count == CNT_W'(PAYLOAD_BYTES - 1)) begin
                        n_state = S_CHECK;
                    end
                end
                S_CHECK: begin
                    n_state = S_SYNC1;
                    n_count = '0;
                    o_push  = (i_rx_byte == r_sum);
                end
                default: begin
                    n_state = S_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SYNC1;
            r_count <= '0;
            r_sum   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store_en) begin
            r_store[r_count[FIELD_IDX_W-1:0]] <= i_rx_byte;
        end
    end

    assign o_frame.distance = {r_store[1], r_store[0]};
    assign o_frame.strength = {r_store[3], r_store[2]};
    assign o_frame.flow_x   = {r_store[5], r_store[4]};
    assign o_frame.flow_y   = {r_store[7], r_store[6]};
    assign o_frame.quality  = r_store[8];

endmodule

FILE: hdl/rffp_queue.sv
// ----------------------------------------------------------------------------
// rffp_queue
// Short frame queue between the parser and the result pipeline.
// ----------------------------------------------------------------------------
module rffp_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  rffp_pkg::t_frame        i_frame,
    input  logic                    i_pop,
    output rffp_pkg::t_frame        o_frame,
    output rffp_pkg::t_queue_status o_status
);
    import rffp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_frame             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push, w_pop;

    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_frame = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

FILE: hdl/rffp_back.sv
// ----------------------------------------------------------------------------
// rffp_back
// Result pipeline: limit checks, flow inversion, gain and divide by 100.
// ----------------------------------------------------------------------------
module rffp_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  rffp_pkg::t_cfg          i_cfg,
    input  rffp_pkg::t_queue_status i_queue,
    input  rffp_pkg::t_frame        i_frame,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [15:0]             o_distance_cm,
    output logic [15:0]             o_signal_strength,
    output logic signed [15:0]      o_flow_x_scaled,
    output logic signed [15:0]      o_flow_y_scaled,
    output logic [7:0]              o_flow_quality,
    output logic                    o_range_ok,
    output logic                    o_flow_ok
);
    import rffp_pkg::*;

    logic        w_en;
    logic        r_v1, r_v2, r_v3;

    // stage 1
    logic [15:0] r1_dist, r1_str;
    logic [7:0]  r1_qual;
    logic        r1_rok, r1_fok;
    logic [26:0] r1_px, r1_py;
    logic [15:0] w_rx, w_ry;
    logic [26:0] w_px, w_py;

    // stage 2
    logic [15:0] r2_dist, r2_str;
    logic [7:0]  r2_qual;
    logic        r2_rok, r2_fok;
    logic        r2_sx, r2_sy;
    logic [51:0] r2_mx, r2_my;
    logic [26:0] w_ax, w_ay;

    // stage 3 (output register)
    logic [19:0] w_qx, w_qy;
    logic [15:0] w_fx, w_fy;

    assign w_en  = !r_v3 || !i_stall;
    assign o_pop = w_en && !i_queue.empty;

    assign w_rx = i_cfg.invert_x ? 16'(~i_frame.flow_x + 16'd1) : i_frame.flow_x;
    assign w_ry = i_cfg.invert_y ? 16'(~i_frame.flow_y + 16'd1) : i_frame.flow_y;
    assign w_px = {{11{w_rx[15]}}, w_rx} * {17'd0, i_cfg.flow_gain_percent};
    assign w_py = {{11{w_ry[15]}}, w_ry} * {17'd0, i_cfg.flow_gain_percent};

    assign w_ax = r1_px[26] ? 27'(~r1_px + 27'd1) : r1_px;
    assign w_ay = r1_py[26] ? 27'(~r1_py + 27'd1) : r1_py;

    assign w_qx = r2_mx[51:32];
    assign w_qy = r2_my[51:32];
    assign w_fx = r2_sx ? 16'(~w_qx[15:0] + 16'd1) : w_qx[15:0];
    assign w_fy = r2_sy ? 16'(~w_qy[15:0] + 16'd1) : w_qy[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= !i_queue.empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dist <= i_frame.distance;
            r1_str  <= i_frame.strength;
            r1_qual <= i_frame.quality;
            r1_rok  <= (i_frame.distance != 16'd0) &&
                       (i_frame.distance >= i_cfg.min_range) &&
                       (i_frame.distance <= i_cfg.max_range) &&
                       (i_frame.strength > {8'd0, STRENGTH_MIN});
            r1_fok  <= (i_frame.quality >= i_cfg.min_flow_quality);
            r1_px   <= w_px;
            r1_py   <= w_py;

            r2_dist <= r1_dist;
            r2_str  <= r1_str;
            r2_qual <= r1_qual;
            r2_rok  <= r1_rok;
            r2_fok  <= r1_fok;
            r2_sx   <= r1_px[26];
            r2_sy   <= r1_py[26];
            r2_mx   <= 52'(w_ax[25:0]) * 52'(RECIP_100);
            r2_my   <= 52'(w_ay[25:0]) * 52'(RECIP_100);

            o_distance_cm     <= r2_dist;
            o_signal_strength <= r2_str;
            o_flow_quality    <= r2_qual;
            o_range_ok        <= r2_rok;
            o_flow_ok         <= r2_fok;
            o_flow_x_scaled   <= w_fx;
            o_flow_y_scaled   <= w_fy;
        end
    end

    assign o_valid = r_v3;

endmodule

FILE: sim/range_flow_frame_parser_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// range_flow_frame_parser_core_tb
// Self-checking bench for the range/flow frame parser. A table of directed
// frames and register writes runs first, then randomized register settings
// with mostly well-formed frames mixed with noise, broken syncs and bad
// checksums. Every accepted byte goes through an in-bench frame decoder; each
// result is compared field by field with the oldest expected frame (decoded,
// or hand-written for some table rows). Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module range_flow_frame_parser_core_tb;
    import rffp_pkg::*;

    localparam int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_BYTES  = 1500;
    localparam int LONG_HOLD     = 400;
    localparam int FRAMES_PER_SET = 20;

    typedef enum logic [1:0] {
        WAIT_SYNC1, WAIT_SYNC2, TAKE_PAYLOAD, TAKE_CHECKSUM
    } t_parse_phase;

    typedef enum logic [2:0] {
        ROW_GOOD, ROW_BAD_SUM, ROW_BAD_SECOND, ROW_HEAD, ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic [15:0] distance_cm;
        logic [15:0] signal_strength;
        logic [15:0] flow_x_scaled;
        logic [15:0] flow_y_scaled;
        logic [7:0]  flow_quality;
        logic        range_ok;
        logic        flow_ok;
    } t_frame_result;

    typedef struct {
        t_row_kind                kind;
        logic                     hand;
        logic [CFG_IDX_W-1:0]     cfg_idx;
        logic [CFG_DATA_W-1:0]    cfg_data;
        logic [15:0]              distance;
        logic [15:0]              strength;
        logic [15:0]              fx;
        logic [15:0]              fy;
        logic [7:0]               quality;
        t_frame_result            want;
    } t_stim_row;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic [7:0]             i_rx_byte   = 8'd0;
    logic                   i_stall     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   o_stall;
    logic                   o_valid;
    logic [15:0]            o_distance_cm;
    logic [15:0]            o_signal_strength;
    logic signed [15:0]     o_flow_x_scaled;
    logic signed [15:0]     o_flow_y_scaled;
    logic [7:0]             o_flow_quality;
    logic                   o_range_ok;
    logic                   o_flow_ok;
    logic                   o_cfg_ready;

    // decoder state and register shadow
    t_cfg                   cfg_shadow;
    t_parse_phase           parse_phase;
    int                     payload_count;
    logic [7:0]             payload_mem [PAYLOAD_BYTES];
    logic [7:0]             sum_acc;

    t_frame_result          expected_frames [$];
    t_stim_row              stim_rows [$];
    int                     fail_count   = 0;
    int                     bytes_sent   = 0;
    int                     idle_pct     = 15;
    logic                   hand_checked = 1'b0;
    logic                   hold_request = 1'b0;

    range_flow_frame_parser_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_rx_byte         (i_rx_byte),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_distance_cm     (o_distance_cm),
        .o_signal_strength (o_signal_strength),
        .o_flow_x_scaled   (o_flow_x_scaled),
        .o_flow_y_scaled   (o_flow_y_scaled),
        .o_flow_quality    (o_flow_quality),
        .o_range_ok        (o_range_ok),
        .o_flow_ok         (o_flow_ok),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [15:0] scale_flow(logic [15:0] raw, logic inv, logic [9:0] gain);
        logic [15:0] v;
        int          prod;
        v = inv ? 16'(0 - raw) : raw;
        prod = (int'($signed(v)) * int'(gain)) / 100;
        return prod[15:0];
    endfunction

    task automatic decode_byte(input logic [7:0] c, output logic got,
                               output t_frame_result res);
        logic [15:0] distance;
        logic [15:0] strength;
        got = 1'b0;
        res = '0;
        case (parse_phase)
            WAIT_SYNC1: begin
                if (c == cfg_shadow.sync_first) begin
                    sum_acc = c;
                    parse_phase = WAIT_SYNC2;
                end
            end
            WAIT_SYNC2: begin
                if (c == cfg_shadow.sync_second) begin
                    sum_acc = sum_acc + c;
                    payload_count = 0;
                    parse_phase = TAKE_PAYLOAD;
                end else begin
                    parse_phase = WAIT_SYNC1;
                end
            end
            TAKE_PAYLOAD: begin
                payload_mem[payload_count] = c;
                sum_acc = sum_acc + c;
                payload_count++;
                if (payload_count >= PAYLOAD_BYTES) parse_phase = TAKE_CHECKSUM;
            end
            default: begin
                parse_phase = WAIT_SYNC1;
                payload_count = 0;
                if (c == sum_acc) begin
                    distance = {payload_mem[1], payload_mem[0]};
                    strength = {payload_mem[3], payload_mem[2]};
                    res.distance_cm = distance;
                    res.signal_strength = strength;
                    res.flow_x_scaled = scale_flow({payload_mem[5], payload_mem[4]},
                                                   cfg_shadow.invert_x,
                                                   cfg_shadow.flow_gain_percent);
                    res.flow_y_scaled = scale_flow({payload_mem[7], payload_mem[6]},
                                                   cfg_shadow.invert_y,
                                                   cfg_shadow.flow_gain_percent);
                    res.flow_quality = payload_mem[8];
                    res.range_ok = distance != 16'd0 && distance >= cfg_shadow.min_range &&
                                   distance <= cfg_shadow.max_range && strength > 16'd100;
                    res.flow_ok = payload_mem[8] >= cfg_shadow.min_flow_quality;
                    got = 1'b1;
                end
            end
        endcase
    endtask

    task automatic send_byte(input logic [7:0] b);
        logic          got;
        t_frame_result res;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        decode_byte(b, got, res);
        bytes_sent++;
        if (got && !hand_checked) expected_frames.push_back(res);
    endtask

    task automatic send_frame(t_row_kind kind, logic [15:0] distance, logic [15:0] strength,
                              logic [15:0] fx, logic [15:0] fy, logic [7:0] q);
        logic [7:0] body [PAYLOAD_BYTES];
        logic [7:0] sum;
        int         n;
        body[0] = distance[7:0];
        body[1] = distance[15:8];
        body[2] = strength[7:0];
        body[3] = strength[15:8];
        body[4] = fx[7:0];
        body[5] = fx[15:8];
        body[6] = fy[7:0];
        body[7] = fy[15:8];
        body[8] = q;
        for (int k = 9; k < PAYLOAD_BYTES; k++) body[k] = 8'($urandom);
        if (kind == ROW_BAD_SECOND) begin
            // wrong second byte equal to the first sync when possible
            send_byte(cfg_shadow.sync_first);
            send_byte(cfg_shadow.sync_first != cfg_shadow.sync_second ?
                      cfg_shadow.sync_first : ~cfg_shadow.sync_second);
        end
        sum = cfg_shadow.sync_first + cfg_shadow.sync_second;
        send_byte(cfg_shadow.sync_first);
        send_byte(cfg_shadow.sync_second);
        n = (kind == ROW_HEAD) ? 6 : PAYLOAD_BYTES;
        for (int k = 0; k < n; k++) begin
            send_byte(body[k]);
            sum = sum + body[k];
        end
        if (kind != ROW_HEAD) begin
            if (kind == ROW_BAD_SUM) sum = sum + 8'($urandom_range(255, 1));
            send_byte(sum);
        end
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SYNC_FIRST:  cfg_shadow.sync_first = data[7:0];
            CFG_SYNC_SECOND: cfg_shadow.sync_second = data[7:0];
            CFG_MIN_RANGE:   cfg_shadow.min_range = data;
            CFG_MAX_RANGE:   cfg_shadow.max_range = data;
            CFG_MIN_QUALITY: cfg_shadow.min_flow_quality = data[7:0];
            CFG_INVERT_X:    cfg_shadow.invert_x = data[0];
            CFG_INVERT_Y:    cfg_shadow.invert_y = data[0];
            CFG_GAIN:        cfg_shadow.flow_gain_percent = data[9:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_frames.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] bound_pick(int lo, int hi);
        int sel;
        sel = $urandom_range(3);
        if (sel == 0) return 16'(lo);
        if (sel == 1) return 16'(hi);
        return 16'($urandom_range(hi, lo));
    endfunction

    function automatic t_stim_row frame_row(t_row_kind kind, logic [15:0] distance,
                                            logic [15:0] strength, logic [15:0] fx,
                                            logic [15:0] fy, logic [7:0] q);
        t_stim_row row;
        row = '{kind: kind, hand: 1'b0, cfg_idx: '0, cfg_data: '0, distance: distance,
                strength: strength, fx: fx, fy: fy, quality: q, want: '0};
        return row;
    endfunction

    function automatic t_stim_row typed_row(t_row_kind kind, logic [15:0] distance,
                                            logic [15:0] strength, logic [15:0] fx,
                                            logic [15:0] fy, logic [7:0] q,
                                            t_frame_result want);
        t_stim_row row;
        row = frame_row(kind, distance, strength, fx, fy, q);
        row.hand = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic t_stim_row cfg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row = frame_row(ROW_CFG, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
        row.cfg_idx = idx;
        row.cfg_data = data;
        return row;
    endfunction

    task automatic check_frame();
        t_frame_result want;
        if (expected_frames.size() == 0) begin
            $error("result transaction with no frame pending: distance_cm %0d",
                   o_distance_cm);
            fail_count++;
            return;
        end
        want = expected_frames.pop_front();
        if (o_distance_cm !== want.distance_cm) begin
            $error("distance_cm: expected %0d, actual %0d", want.distance_cm, o_distance_cm);
            fail_count++;
        end
        if (o_signal_strength !== want.signal_strength) begin
            $error("signal_strength: expected %0d, actual %0d",
                   want.signal_strength, o_signal_strength);
            fail_count++;
        end
        if (o_flow_x_scaled !== want.flow_x_scaled) begin
            $error("flow_x_scaled: expected %0d, actual %0d",
                   $signed(want.flow_x_scaled), o_flow_x_scaled);
            fail_count++;
        end
        if (o_flow_y_scaled !== want.flow_y_scaled) begin
            $error("flow_y_scaled: expected %0d, actual %0d",
                   $signed(want.flow_y_scaled), o_flow_y_scaled);
            fail_count++;
        end
        if (o_flow_quality !== want.flow_quality) begin
            $error("flow_quality: expected %0d, actual %0d", want.flow_quality, o_flow_quality);
            fail_count++;
        end
        if (o_range_ok !== want.range_ok) begin
            $error("range_ok: expected %0d, actual %0d", want.range_ok, o_range_ok);
            fail_count++;
        end
        if (o_flow_ok !== want.flow_ok) begin
            $error("flow_ok: expected %0d, actual %0d", want.flow_ok, o_flow_ok);
            fail_count++;
        end
    endtask

    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) check_frame();
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < idle_pct);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int          rand_start;
        int          set_no;
        int          pick;
        t_row_kind   kind;
        logic [15:0] distance;
        logic [15:0] strength;
        logic [15:0] fx;
        logic [15:0] fy;
        logic [7:0]  q;

        cfg_shadow = '{sync_first: 8'd90, sync_second: 8'd0, min_range: 16'd0,
                       max_range: 16'hFFFF, min_flow_quality: 8'd0, invert_x: 1'b0,
                       invert_y: 1'b0, flow_gain_percent: 10'd100};
        parse_phase = WAIT_SYNC1;
        payload_count = 0;
        sum_acc = 8'd0;

        // defaults: sync 90/0, range 0..65535, quality 0, gain 100
        stim_rows.push_back(typed_row(ROW_GOOD, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0,
            {16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 1'b0, 1'b1}));
        stim_rows.push_back(typed_row(ROW_GOOD, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF,
            {16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF, 1'b1, 1'b1}));
        stim_rows.push_back(typed_row(ROW_GOOD, 16'd1, 16'd100, 16'hFFFF, 16'h0001, 8'h80,
            {16'd1, 16'd100, 16'hFFFF, 16'h0001, 8'h80, 1'b0, 1'b1}));
        stim_rows.push_back(typed_row(ROW_GOOD, 16'd1, 16'd101, 16'h1234, 16'hEDCC, 8'h01,
            {16'd1, 16'd101, 16'h1234, 16'hEDCC, 8'h01, 1'b1, 1'b1}));
        stim_rows.push_back(typed_row(ROW_BAD_SUM, 16'd500, 16'd500, 16'd0, 16'd0, 8'd0, '0));
        stim_rows.push_back(frame_row(ROW_BAD_SECOND, 16'd300, 16'd200, 16'd10, 16'hFFF6, 8'd50));
        stim_rows.push_back(cfg_row(CFG_INVERT_X, 16'd1));
        stim_rows.push_back(cfg_row(CFG_INVERT_Y, 16'hFFFF));
        stim_rows.push_back(frame_row(ROW_GOOD, 16'd10, 16'd200, 16'h8000, 16'h0001, 8'd7));
        stim_rows.push_back(cfg_row(CFG_GAIN, 16'hFFFF));
        stim_rows.push_back(frame_row(ROW_GOOD, 16'd20, 16'd200, 16'h7FFF, 16'h8000, 8'd9));
        stim_rows.push_back(cfg_row(CFG_GAIN, 16'd0));
        stim_rows.push_back(frame_row(ROW_GOOD, 16'd30, 16'd300, 16'h1234, 16'h8765, 8'd3));
        stim_rows.push_back(cfg_row(CFG_MIN_RANGE, 16'hFFFF));
        stim_rows.push_back(cfg_row(CFG_MAX_RANGE, 16'd0));
        stim_rows.push_back(cfg_row(CFG_MIN_QUALITY, 16'd255));
        stim_rows.push_back(cfg_row(CFG_INVERT_X, 16'd0));
        stim_rows.push_back(cfg_row(CFG_GAIN, 16'd1000));
        stim_rows.push_back(frame_row(ROW_GOOD, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8001, 8'hFF));
        stim_rows.push_back(frame_row(ROW_GOOD, 16'd0, 16'd101, 16'hC000, 16'h4000, 8'hFE));
        stim_rows.push_back(cfg_row(CFG_MIN_RANGE, 16'd500));
        stim_rows.push_back(cfg_row(CFG_MAX_RANGE, 16'd500));
        stim_rows.push_back(cfg_row(CFG_MIN_QUALITY, 16'd0));
        stim_rows.push_back(frame_row(ROW_GOOD, 16'd500, 16'd101, 16'd999, 16'hFC19, 8'd0));
        stim_rows.push_back(frame_row(ROW_GOOD, 16'd501, 16'd101, 16'd1, 16'd2, 8'd1));
        stim_rows.push_back(frame_row(ROW_GOOD, 16'd499, 16'd5000, 16'd3, 16'd4, 8'd2));
        // sync values change while a frame is half received
        stim_rows.push_back(frame_row(ROW_HEAD, 16'd42, 16'd420, 16'd5, 16'd6, 8'd7));
        stim_rows.push_back(cfg_row(CFG_SYNC_FIRST, 16'hFFFF));
        stim_rows.push_back(cfg_row(CFG_SYNC_SECOND, 16'h00FF));
        stim_rows.push_back(frame_row(ROW_GOOD, 16'd500, 16'd150, 16'd77, 16'd88, 8'd9));
        stim_rows.push_back(frame_row(ROW_GOOD, 16'd500, 16'd150, 16'h8000, 16'h7FFF, 8'd9));
        stim_rows.push_back(frame_row(ROW_BAD_SECOND, 16'd500, 16'd150, 16'd1, 16'd1, 8'd1));
        stim_rows.push_back(cfg_row(CFG_SYNC_FIRST, 16'h0000));
        stim_rows.push_back(cfg_row(CFG_SYNC_SECOND, 16'h005A));
        stim_rows.push_back(cfg_row(CFG_INVERT_Y, 16'd0));
        stim_rows.push_back(cfg_row(CFG_GAIN, 16'd100));
        stim_rows.push_back(frame_row(ROW_GOOD, 16'd500, 16'd65535, 16'h0101, 16'hFEFE, 8'd255));
        stim_rows.push_back(frame_row(ROW_BAD_SUM, 16'd500, 16'd150, 16'd1, 16'd1, 8'd1));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[r]) begin
            if (stim_rows[r].kind == ROW_CFG) begin
                wait_drain();
                cfg_write(stim_rows[r].cfg_idx, stim_rows[r].cfg_data);
            end else begin
                hand_checked = stim_rows[r].hand;
                send_frame(stim_rows[r].kind, stim_rows[r].distance, stim_rows[r].strength,
                           stim_rows[r].fx, stim_rows[r].fy, stim_rows[r].quality);
                if (stim_rows[r].hand && stim_rows[r].kind == ROW_GOOD)
                    expected_frames.push_back(stim_rows[r].want);
                hand_checked = 1'b0;
            end
        end

        rand_start = bytes_sent;
        set_no = 0;
        while (bytes_sent - rand_start < RANDOM_BYTES) begin
            wait_drain();
            if ($urandom_range(1)) cfg_write(CFG_SYNC_FIRST, 16'($urandom));
            if ($urandom_range(1)) cfg_write(CFG_SYNC_SECOND, 16'($urandom));
            if ($urandom_range(3) != 0) cfg_write(CFG_MIN_RANGE, bound_pick(0, 4000));
            if ($urandom_range(3) != 0) cfg_write(CFG_MAX_RANGE, bound_pick(2000, 65535));
            if ($urandom_range(3) != 0)
                cfg_write(CFG_MIN_QUALITY, {8'($urandom), 8'(bound_pick(0, 255))});
            if ($urandom_range(1)) cfg_write(CFG_INVERT_X, 16'($urandom));
            if ($urandom_range(1)) cfg_write(CFG_INVERT_Y, 16'($urandom));
            if ($urandom_range(3) != 0)
                cfg_write(CFG_GAIN, {6'($urandom), 10'(bound_pick(0, 1023))});

            idle_pct = (set_no == 1) ? 0 : 15;
            if (set_no == 2) hold_request = 1'b1;

            for (int f = 0; f < FRAMES_PER_SET; f++) begin
                pick = $urandom_range(99);
                if (pick >= 90) begin
                    repeat ($urandom_range(5, 1)) send_byte(8'($urandom));
                end else begin
                    kind = pick < 72 ? ROW_GOOD : pick < 80 ? ROW_BAD_SUM :
                           pick < 87 ? ROW_BAD_SECOND : ROW_HEAD;
                    case ($urandom_range(5))
                        0: distance = cfg_shadow.min_range;
                        1: distance = cfg_shadow.max_range;
                        2: distance = cfg_shadow.min_range - 16'd1;
                        3: distance = cfg_shadow.max_range + 16'd1;
                        4: distance = 16'($urandom_range(5000));
                        default: distance = 16'($urandom);
                    endcase
                    case ($urandom_range(3))
                        0: strength = 16'd100;
                        1: strength = 16'd101;
                        2: strength = 16'($urandom_range(200));
                        default: strength = 16'($urandom);
                    endcase
                    case ($urandom_range(4))
                        0: fx = 16'h8000;
                        1: fx = 16'h7FFF;
                        2: fx = 16'($urandom_range(200)) - 16'd100;
                        default: fx = 16'($urandom);
                    endcase
                    case ($urandom_range(4))
                        0: fy = 16'h8000;
                        1: fy = 16'h7FFF;
                        2: fy = 16'($urandom_range(200)) - 16'd100;
                        default: fy = 16'($urandom);
                    endcase
                    case ($urandom_range(2))
                        0: q = cfg_shadow.min_flow_quality;
                        1: q = cfg_shadow.min_flow_quality - 8'd1;
                        default: q = 8'($urandom);
                    endcase
                    send_frame(kind, distance, strength, fx, fy, q);
                end
            end
            set_no++;
        end

        idle_pct = 15;
        wait_drain();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
hdl/rffp_pkg.sv
hdl/rffp_front.sv
hdl/rffp_queue.sv
hdl/rffp_back.sv
hdl/range_flow_frame_parser_core.sv
sim/range_flow_frame_parser_core_tb.sv
